FILE: rtl/core/ffha_pkg.sv
// constants, types and codes of the first-fit heap allocator
// used by the channel interfaces and the allocator core
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int HEAP_BYTES   = 1048576;
    localparam int BLOCK_BYTES  = 64;
    localparam int DESC_BYTES   = 24;
    localparam int HEADER_BYTES = 8;
    localparam int MAX_SEGS     = 64;

    localparam int ADDR_W = 20;
    localparam int BLK_W  = 15;
    localparam int STAT_W = 2;
    localparam int IDX_W  = $clog2(MAX_SEGS);
    localparam int CNT_W  = $clog2(MAX_SEGS + 1);
    localparam int NEED_W = BLK_W + $clog2(BLOCK_BYTES) + 1;

    // operation codes
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;

    localparam logic [ADDR_W-1:0] DESC_SZ   = ADDR_W'(DESC_BYTES);
    localparam logic [ADDR_W-1:0] SPLIT_MIN = ADDR_W'(DESC_BYTES + BLOCK_BYTES);

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              is_free;
    } t_seg;

    localparam t_seg RESET_SEG = '{
        start:   ADDR_W'(HEADER_BYTES),
        size:    ADDR_W'(HEAP_BYTES - HEADER_BYTES - DESC_BYTES),
        is_free: 1'b1
    };

endpackage

FILE: rtl/core/ffha_if.sv
// valid/ready channel interfaces for requests and responses
// depends on ffha_pkg
`timescale 1ns / 1ps

interface ffha_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [ffha_pkg::BLK_W-1:0]  block_count;
    logic [ffha_pkg::ADDR_W-1:0] user_address;

    modport source (output valid, func, block_count, user_address, input ready);
    modport sink   (input valid, func, block_count, user_address, output ready);
endinterface

interface ffha_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ffha_pkg::ADDR_W-1:0] result_address;
    logic [ffha_pkg::STAT_W-1:0] status;

    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

FILE: rtl/core/first_fit_heap_allocator.sv
// first-fit heap allocator core, depends on ffha_pkg and ffha_if
// the scan reads and checks table entries in order up to the hit; an alloc may then split
// and shift entries up, a free runs merge checks and may shift entries down; then respond
// throughput: one transaction in work at a time, the next accepted on return to idle;
// a response still waiting in the output register holds the core in its last state
// reset clears control state and seeds entry 0 as the whole heap through a flag
`timescale 1ns / 1ps

module first_fit_heap_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffha_req_if.sink   i_req,
    ffha_rsp_if.source o_rsp
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRD  = 4'd1;
    localparam logic [3:0] S_SCHK = 4'd2;
    localparam logic [3:0] S_IRD  = 4'd3;
    localparam logic [3:0] S_IWR  = 4'd4;
    localparam logic [3:0] S_INEW = 4'd5;
    localparam logic [3:0] S_ICUR = 4'd6;
    localparam logic [3:0] S_NRD  = 4'd7;
    localparam logic [3:0] S_NCHK = 4'd8;
    localparam logic [3:0] S_PCHK = 4'd9;
    localparam logic [3:0] S_DRD  = 4'd10;
    localparam logic [3:0] S_DWR  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int AW = ffha_pkg::ADDR_W;
    localparam int NW = ffha_pkg::NEED_W;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_fresh;
    logic          r_out_valid, n_out_valid;
    logic [AW-1:0] r_out_addr, n_out_addr;
    logic [ffha_pkg::STAT_W-1:0] r_out_st, n_out_st;
    logic          r_func, n_func;
    logic [NW-1:0] r_need, n_need;
    logic [AW-1:0] r_addr, n_addr;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_j, n_j;
    logic [1:0]    r_dist, n_dist;
    logic          r_mnext, n_mnext;
    ffha_pkg::t_seg r_cur, n_cur;
    ffha_pkg::t_seg r_prev, n_prev;
    logic [AW-1:0] r_res_addr, n_res_addr;
    logic [ffha_pkg::STAT_W-1:0] r_res_st, n_res_st;

    // segment table
    ffha_pkg::t_seg r_mem [ffha_pkg::MAX_SEGS];
    ffha_pkg::t_seg r_rd;
    logic [IW-1:0]  r_rd_addr;
    logic [IW-1:0]  rd_addr;
    logic           w_en;
    logic [IW-1:0]  w_addr;
    ffha_pkg::t_seg w_data;
    ffha_pkg::t_seg rd_data;

    logic          hit;
    logic [AW-1:0] rest;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] j_far;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd      <= r_mem[rd_addr];
        r_rd_addr <= rd_addr;
    end

    // entry 0 reads as the whole heap until first written
    assign rd_data = (r_fresh && r_rd_addr == '0) ? ffha_pkg::RESET_SEG : r_rd;

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.status         = r_out_st;

    assign idx_next = CW'(r_idx) + CW'(1);
    assign j_far    = CW'(r_j) + CW'(r_dist);
    assign rest     = rd_data.size - r_need[AW-1:0];

    // hit test of the scan
    always_comb begin
        if (r_func == ffha_pkg::FN_ALLOC) begin
            hit = rd_data.is_free && (NW'(rd_data.size) >= r_need);
        end else begin
            hit = !rd_data.is_free &&
                  ({1'b0, rd_data.start} + {1'b0, ffha_pkg::DESC_SZ} == {1'b0, r_addr});
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_st    = r_out_st;
        n_func      = r_func;
        n_need      = r_need;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_j         = r_j;
        n_dist      = r_dist;
        n_mnext     = r_mnext;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_res_addr  = r_res_addr;
        n_res_st    = r_res_st;
        rd_addr     = r_idx;
        w_en        = 1'b0;
        w_addr      = r_pos;
        w_data      = r_cur;

        // response taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_need  = NW'(i_req.block_count) * NW'(ffha_pkg::BLOCK_BYTES);
                    n_addr  = i_req.user_address;
                    n_idx   = '0;
                    n_mnext = 1'b0;
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                rd_addr = r_idx;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (hit) begin
                    n_cur    = rd_data;
                    n_pos    = r_idx;
                    n_res_st = ffha_pkg::ST_OK;
                    if (r_func == ffha_pkg::FN_ALLOC) begin
                        n_res_addr = rd_data.start + ffha_pkg::DESC_SZ;
                        if (rest >= ffha_pkg::SPLIT_MIN &&
                            r_cnt < CW'(ffha_pkg::MAX_SEGS)) begin
                            n_j = IW'(r_cnt - CW'(1));
                            n_state = (r_cnt - CW'(1) > CW'(r_idx)) ? S_IRD : S_INEW;
                        end else begin
                            w_en    = 1'b1;
                            w_addr  = r_idx;
                            w_data  = rd_data;
                            w_data.is_free = 1'b0;
                            n_state = S_DONE;
                        end
                    end else begin
                        n_res_addr  = '0;
                        n_cur.is_free = 1'b1;
                        n_state = (idx_next < r_cnt) ? S_NRD : S_PCHK;
                    end
                end else begin
                    n_prev = rd_data;
                    if (idx_next >= r_cnt) begin
                        n_res_addr = '0;
                        n_res_st   = (r_func == ffha_pkg::FN_ALLOC) ?
                                     ffha_pkg::ST_NOFIT : ffha_pkg::ST_UNKNOWN;
                        n_state    = S_DONE;
                    end else begin
                        n_idx   = IW'(idx_next);
                        n_state = S_SRD;
                    end
                end
            end
            // shift entries up to open a slot after the hit
            S_IRD: begin
                rd_addr = r_j;
                n_state = S_IWR;
            end
            S_IWR: begin
                w_en   = 1'b1;
                w_addr = r_j + IW'(1);
                w_data = rd_data;
                if (r_j > r_pos + IW'(1)) begin
                    n_j     = r_j - IW'(1);
                    n_state = S_IRD;
                end else begin
                    n_state = S_INEW;
                end
            end
            S_INEW: begin
                w_en           = 1'b1;
                w_addr         = r_pos + IW'(1);
                w_data.start   = r_cur.start + ffha_pkg::DESC_SZ + r_need[AW-1:0];
                w_data.size    = r_cur.size - r_need[AW-1:0] - ffha_pkg::DESC_SZ;
                w_data.is_free = 1'b1;
                n_state        = S_ICUR;
            end
            S_ICUR: begin
                w_en           = 1'b1;
                w_addr         = r_pos;
                w_data.start   = r_cur.start;
                w_data.size    = r_need[AW-1:0];
                w_data.is_free = 1'b0;
                n_cnt          = r_cnt + CW'(1);
                n_state        = S_DONE;
            end
            // free: merge with the next entry
            S_NRD: begin
                rd_addr = r_pos + IW'(1);
                n_state = S_NCHK;
            end
            S_NCHK: begin
                if (rd_data.is_free) begin
                    n_cur.size = r_cur.size + ffha_pkg::DESC_SZ + rd_data.size;
                    n_mnext    = 1'b1;
                end
                n_state = S_PCHK;
            end
            // free: merge with the previous entry
            S_PCHK: begin
                w_en = 1'b1;
                if (r_pos != '0 && r_prev.is_free) begin
                    w_addr      = r_pos - IW'(1);
                    w_data      = r_prev;
                    w_data.size = r_prev.size + ffha_pkg::DESC_SZ + r_cur.size;
                    n_dist      = r_mnext ? 2'd2 : 2'd1;
                    n_j         = r_pos;
                    n_state     = S_DRD;
                end else begin
                    w_addr = r_pos;
                    w_data = r_cur;
                    n_dist = 2'd1;
                    n_j    = r_pos + IW'(1);
                    n_state = r_mnext ? S_DRD : S_DONE;
                end
            end
            // close the gap left by merged entries
            S_DRD: begin
                if (j_far < r_cnt) begin
                    rd_addr = IW'(j_far);
                    n_state = S_DWR;
                end else begin
                    n_cnt   = r_cnt - CW'(r_dist);
                    n_state = S_DONE;
                end
            end
            S_DWR: begin
                w_en    = 1'b1;
                w_addr  = r_j;
                w_data  = rd_data;
                n_j     = r_j + IW'(1);
                n_state = S_DRD;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= CW'(1);
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (w_en && w_addr == '0) begin
                r_fresh <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out_addr <= n_out_addr;
        r_out_st   <= n_out_st;
        r_func     <= n_func;
        r_need     <= n_need;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_j        <= n_j;
        r_dist     <= n_dist;
        r_mnext    <= n_mnext;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
    end

endmodule
